>>> sv/npve_pkg.sv
// Shared types, register indexes and saturation helper for the nested
// polygon vertex expander. No dependencies.
package npve_pkg;

    typedef struct packed {
        logic signed [15:0] vertex_x;
        logic signed [15:0] vertex_y;
    } npve_in_t;

    typedef struct packed {
        logic [3:0]         level;
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic               last_level;
    } npve_out_t;

    typedef enum logic [2:0] {
        REG_LEVEL_COUNT = 3'd0,
        REG_MATRIX_XX   = 3'd1,
        REG_MATRIX_XY   = 3'd2,
        REG_MATRIX_YX   = 3'd3,
        REG_MATRIX_YY   = 3'd4
    } npve_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_R_XX,
        ST_R_YY,
        ST_R_SUM,
        ST_SQRT,
        ST_DIV,
        ST_EMIT,
        ST_SC_X,
        ST_SC_Y,
        ST_M_XX,
        ST_M_XY,
        ST_M_YX,
        ST_M_YY,
        ST_M_END
    } npve_state_t;

    localparam int ProdW = 42;

    function automatic logic signed [15:0] sat16(input logic signed [ProdW-1:0] v);
        logic signed [15:0] r;
        if (v > 42'sd32767)
            r = 16'sh7FFF;
        else if (v < -42'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

endpackage

>>> sv/npve_sqrt.sv
// Iterative integer square root, one result bit per cycle.
// No dependency on npve_pkg; no imports needed.
module npve_sqrt
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [47:0] radicand,
    output logic        done,
    output logic [23:0] root
);

    logic [47:0] rad_reg, rad_next;
    logic [25:0] rem_reg, rem_next;
    logic [23:0] root_reg, root_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [27:0] rem_sh;
    logic [27:0] trial;

    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg, rad_reg[47:46]};
        trial     = {2'b00, root_reg, 2'b01};
        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = 5'd23;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[45:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = 26'(rem_sh - trial);
                root_next = {root_reg[22:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh[25:0];
                root_next = {root_reg[22:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

>>> sv/npve_div.sv
// Iterative restoring divider, 33-bit dividend by 24-bit divisor, one
// quotient bit per cycle. No package dependency.
module npve_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [32:0] dividend,
    input  logic [23:0] divisor,
    output logic        done,
    output logic [24:0] quotient
);

    logic [32:0] dvd_reg, dvd_next;
    logic [23:0] dsr_reg, dsr_next;
    logic [23:0] rem_reg, rem_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [24:0] rem_sh;

    always_comb
    begin
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg, dvd_reg[32]};
        if (start)
        begin
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift quotient bits in from the bottom as dividend bits leave the top
            if (rem_sh >= {1'b0, dsr_reg})
            begin
                rem_next = 24'(rem_sh - {1'b0, dsr_reg});
                dvd_next = {dvd_reg[31:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[23:0];
                dvd_next = {dvd_reg[31:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg[24:0];

endmodule

>>> sv/npve_mul.sv
// Shared signed 16 x 26 multiplier with a registered product.
// Depends on npve_pkg for the product width.
module npve_mul
    import npve_pkg::*;
(
    input  logic                    clk,
    input  logic signed [15:0]      a,
    input  logic signed [25:0]      b,
    output logic signed [ProdW-1:0] prod
);

    logic signed [ProdW-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= ProdW'(a * b);
    end

    assign prod = prod_reg;

endmodule

>>> sv/nested_polygon_vertex_expander.sv
// From a request to level 0: |v|^2 on the shared multiplier, the bit-serial square root
// and divide, then the output load; each further level scales and applies the matrix.
// An origin vertex skips the root. One vertex is worked at a time, through the shared
// multiplier and the bit-serial root and divide units. A new vertex is taken once the last
// level is in the output register. Reset clears control state and loads the
// register defaults (one level, identity matrix).
module nested_polygon_vertex_expander
    import npve_pkg::*;
#(
    parameter int MAX_LEVELS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  npve_in_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output npve_out_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int CW = $clog2(MAX_LEVELS + 1);

    npve_state_t state_reg, state_next;

    logic [4:0]         level_count_reg;
    logic signed [15:0] mxx_reg, mxy_reg, myx_reg, myy_reg;

    logic signed [15:0] cur_x_reg, cur_y_reg, px_reg, py_reg;
    logic signed [ProdW-1:0] acc_reg;
    logic [24:0]        s_reg;
    logic [CW-1:0]      lvl_reg, n_reg;
    logic               out_valid_reg;
    npve_out_t          out_data_reg;

    logic signed [15:0]      mul_a;
    logic signed [25:0]      mul_b;
    logic signed [ProdW-1:0] prod;
    logic signed [ProdW-1:0] sum;
    logic signed [ProdW-1:0] r16, r14;
    logic [6:0]         lc_w;
    logic [CW-1:0]      n_clamp;
    logic               last;
    logic               can_load;
    logic               accept;
    logic               sqrt_start, sqrt_done, div_start, div_done;
    logic [23:0]        root;
    logic [24:0]        quot;

    npve_mul u_mul
    (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    npve_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand ({sum[31:0], 16'h0000}),
        .done     (sqrt_done),
        .root     (root)
    );

    npve_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({1'b1, 9'h000, root[23:1]}),
        .divisor  (root),
        .done     (div_done),
        .quotient (quot)
    );

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign sum      = acc_reg + prod;
    assign r16      = (prod + 42'sd32768) >>> 16;
    assign r14      = (sum + 42'sd8192) >>> 14;
    assign can_load = !out_valid_reg || !out_stall;
    assign last     = ((CW+1)'(lvl_reg) + (CW+1)'(1)) == (CW+1)'(n_reg);

    always_comb
    begin
        lc_w = 7'(level_count_reg);
        if (lc_w == 7'd0)
            n_clamp = CW'(1);
        else if (lc_w > 7'(MAX_LEVELS))
            n_clamp = CW'(MAX_LEVELS);
        else
            n_clamp = CW'(lc_w);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_R_XX;
            ST_R_XX:  state_next = ST_R_YY;
            ST_R_YY:  state_next = ST_R_SUM;
            ST_R_SUM: state_next = (sum == '0) ? ST_EMIT : ST_SQRT;
            ST_SQRT:  if (sqrt_done) state_next = ST_DIV;
            ST_DIV:   if (div_done) state_next = ST_EMIT;
            ST_EMIT:  if (can_load) state_next = last ? ST_IDLE : ST_SC_X;
            ST_SC_X:  state_next = ST_SC_Y;
            ST_SC_Y:  state_next = ST_M_XX;
            ST_M_XX:  state_next = ST_M_XY;
            ST_M_XY:  state_next = ST_M_YX;
            ST_M_YX:  state_next = ST_M_YY;
            ST_M_YY:  state_next = ST_M_END;
            ST_M_END: state_next = ST_EMIT;
            default:  state_next = ST_IDLE;
        endcase
    end

    // multiplier operands and unit starts
    always_comb
    begin
        mul_a      = cur_x_reg;
        mul_b      = 26'(cur_x_reg);
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            ST_R_XX:
            begin
                mul_a = cur_x_reg;
                mul_b = 26'(cur_x_reg);
            end
            ST_R_YY:
            begin
                mul_a = cur_y_reg;
                mul_b = 26'(cur_y_reg);
            end
            ST_R_SUM: sqrt_start = (sum != '0);
            ST_SQRT:  div_start = sqrt_done;
            ST_SC_X:
            begin
                mul_a = cur_x_reg;
                mul_b = {1'b0, s_reg};
            end
            ST_SC_Y:
            begin
                mul_a = cur_y_reg;
                mul_b = {1'b0, s_reg};
            end
            ST_M_XX:
            begin
                mul_a = mxx_reg;
                mul_b = 26'(px_reg);
            end
            ST_M_XY:
            begin
                mul_a = mxy_reg;
                mul_b = 26'(py_reg);
            end
            ST_M_YX:
            begin
                mul_a = myx_reg;
                mul_b = 26'(px_reg);
            end
            ST_M_YY:
            begin
                mul_a = myy_reg;
                mul_b = 26'(py_reg);
            end
            default:
            begin
                mul_a = cur_x_reg;
                mul_b = 26'(cur_x_reg);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            level_count_reg <= 5'd1;
            mxx_reg         <= 16'sd16384;
            mxy_reg         <= 16'sd0;
            myx_reg         <= 16'sd0;
            myy_reg         <= 16'sd16384;
            lvl_reg         <= '0;
            n_reg           <= CW'(1);
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_LEVEL_COUNT: level_count_reg <= cfg_data[4:0];
                    REG_MATRIX_XX:   mxx_reg <= cfg_data;
                    REG_MATRIX_XY:   mxy_reg <= cfg_data;
                    REG_MATRIX_YX:   myx_reg <= cfg_data;
                    REG_MATRIX_YY:   myy_reg <= cfg_data;
                    default:         ;
                endcase
            end
            if (accept)
            begin
                lvl_reg <= '0;
                n_reg   <= n_clamp;
            end
            else if (state_reg == ST_EMIT && can_load && !last)
                lvl_reg <= lvl_reg + CW'(1);
            if (state_reg == ST_EMIT && can_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_x_reg <= in_data.vertex_x;
            cur_y_reg <= in_data.vertex_y;
            s_reg     <= 25'h10000;
        end
        case (state_reg)
            ST_R_YY:  acc_reg <= prod;
            ST_DIV:   if (div_done) s_reg <= 25'h10000 + quot;
            ST_SC_Y:  px_reg <= sat16(r16);
            ST_M_XX:  py_reg <= sat16(r16);
            ST_M_XY:  acc_reg <= prod;
            ST_M_YX:  cur_x_reg <= sat16(r14);
            ST_M_YY:  acc_reg <= prod;
            ST_M_END: cur_y_reg <= sat16(r14);
            default:  ;
        endcase
        if (state_reg == ST_EMIT && can_load)
        begin
            out_data_reg.level      <= 4'(lvl_reg);
            out_data_reg.out_x      <= cur_x_reg;
            out_data_reg.out_y      <= cur_y_reg;
            out_data_reg.last_level <= last;
        end
    end

    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("request taken but block not busy next cycle");

    a_sqrt_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_done |-> state_reg == ST_SQRT)
        else $error("square root finished outside its wait state");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divide finished outside its wait state");

    a_level_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> lvl_reg < n_reg)
        else $error("level counter ran past the level count");

endmodule
